>>> design/jpfd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpfd_pkg
// Types, constants and the command length table shared by the decoder.
// ---------------------------------------------------------------------------
package jpfd_pkg;

    localparam int DEF_MAX_BYTES  = 64;
    localparam int DEF_MAX_PULSES = 1024;

    // pulse index at which the command byte is complete
    localparam int CMD_PULSES = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD_MIN    = 2'd0;
    localparam logic [1:0] CFG_PERIOD_MAX    = 2'd1;
    localparam logic [1:0] CFG_ONE_THRESHOLD = 2'd2;

    localparam logic [15:0] RST_PERIOD_MIN    = 16'd7;
    localparam logic [15:0] RST_PERIOD_MAX    = 16'd9;
    localparam logic [14:0] RST_ONE_THRESHOLD = 15'd4;

    // result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [14:0] low_ticks;
        logic [14:0] high_ticks;
    } t_pulse;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic [5:0] byte_index;
        logic       in_response;
        logic [9:0] stop_position;
        logic [6:0] byte_count;
    } t_result;

    // classified pulse passed from front to back
    typedef struct packed {
        logic eof;
        logic bad;
        logic one;
    } t_pulse_cls;

    // command length in bytes, zero for an unknown command
    function automatic logic [7:0] cmd_len(input logic [7:0] cmd);
        logic [7:0] len;
        case (cmd)
            8'h00: len = 8'h01;
            8'h01: len = 8'h01;
            8'h02: len = 8'h03;
            8'h03: len = 8'h23;
            8'h08: len = 8'h01;
            8'h09: len = 8'h03;
            8'h0A: len = 8'h17;
            8'h0B: len = 8'h03;
            8'h0C: len = 8'h07;
            8'h0D: len = 8'h03;
            8'h13: len = 8'h02;
            8'h30: len = 8'h03;
            8'h40: len = 8'h03;
            8'h41: len = 8'h03;
            8'h42: len = 8'h03;
            8'h4E: len = 8'h03;
            8'h54: len = 8'h03;
            8'hFF: len = 8'h01;
            default: len = 8'h00;
        endcase
        return len;
    endfunction

endpackage

>>> design/jpfd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpfd_front
// Configuration registers and per-pulse classification (end of frame,
// window check, bit value).
// ---------------------------------------------------------------------------
module jpfd_front import jpfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_pulse      i_pulse,
    output t_pulse_cls  o_cls
);

    logic [15:0] r_period_min;
    logic [15:0] r_period_max;
    logic [14:0] r_one_threshold;
    logic [15:0] period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_min    <= RST_PERIOD_MIN;
            r_period_max    <= RST_PERIOD_MAX;
            r_one_threshold <= RST_ONE_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PERIOD_MIN:    r_period_min    <= i_cfg_data;
                CFG_PERIOD_MAX:    r_period_max    <= i_cfg_data;
                CFG_ONE_THRESHOLD: r_one_threshold <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign period = 16'(i_pulse.low_ticks) + 16'(i_pulse.high_ticks);

    assign o_cls.eof = (i_pulse.high_ticks == 15'd0);
    assign o_cls.bad = (period < r_period_min) || (period > r_period_max);
    assign o_cls.one = (i_pulse.high_ticks > r_one_threshold);

endmodule

>>> design/jpfd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpfd_queue
// Two-entry queue of classified pulses between front and back.
// ---------------------------------------------------------------------------
module jpfd_queue import jpfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_pulse_cls i_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_pulse_cls o_data
);

    t_pulse_cls r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> design/jpfd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpfd_back
// Frame state: bit assembly, stop bit tracking, byte and summary results,
// held in an output register.
// ---------------------------------------------------------------------------
module jpfd_back import jpfd_pkg::*; #(
    parameter int MAX_BYTES  = DEF_MAX_BYTES,
    parameter int MAX_PULSES = DEF_MAX_PULSES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_pulse_cls i_q_data,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_result    o_out_data
);

    localparam int PIW = $clog2(MAX_PULSES + 1);
    localparam int LBW = $clog2(MAX_PULSES);
    localparam int BCW = $clog2(MAX_BYTES * 8 + 1);
    localparam int BNW = BCW - 3;
    localparam int SKW = (PIW > 11) ? PIW : 11;

    logic [PIW-1:0] r_pulse_index, n_pulse_index;
    logic [BCW-1:0] r_bit_count, n_bit_count;
    logic [SKW-1:0] r_skip_pos, n_skip_pos;
    logic [LBW-1:0] r_last_bad, n_last_bad;
    logic [7:0]     r_shift, n_shift;
    logic [7:0]     r_cmd, n_cmd;
    logic           r_past_stop, n_past_stop;
    logic           r_out_valid;
    t_result        r_out_data, n_out_data;
    logic           emit;

    logic [BCW-1:0] bc_inc;
    logic [BNW-1:0] byte_no;
    logic [7:0]     shift_in;
    logic [SKW-1:0] idx_ext;

    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign bc_inc   = r_bit_count + BCW'(1);
    assign byte_no  = BNW'((bc_inc >> 3) - BCW'(1));
    assign shift_in = {r_shift[6:0], i_q_data.one};
    assign idx_ext  = SKW'(r_pulse_index);

    always_comb begin
        n_pulse_index = r_pulse_index;
        n_bit_count   = r_bit_count;
        n_skip_pos    = r_skip_pos;
        n_last_bad    = r_last_bad;
        n_shift       = r_shift;
        n_cmd         = r_cmd;
        n_past_stop   = r_past_stop;
        emit          = 1'b0;
        n_out_data    = '0;

        if (i_q_data.eof) begin
            emit                     = 1'b1;
            n_out_data.kind          = KIND_SUMMARY;
            n_out_data.stop_position = 10'(r_last_bad);
            n_out_data.byte_count    = 7'(r_bit_count >> 3);
            n_pulse_index = '0;
            n_bit_count   = '0;
            n_skip_pos    = '0;
            n_last_bad    = '0;
            n_shift       = '0;
            n_cmd         = '0;
            n_past_stop   = 1'b0;
        end else if (r_pulse_index < PIW'(MAX_PULSES)) begin
            n_pulse_index = r_pulse_index + PIW'(1);
            if (r_pulse_index == PIW'(CMD_PULSES)) begin
                n_skip_pos = SKW'({cmd_len(r_cmd), 3'b000});
            end
            if (i_q_data.bad) begin
                n_last_bad = LBW'(r_pulse_index);
                // unknown command: first late out-of-window pulse is the stop bit
                if (n_skip_pos == '0 && r_pulse_index > PIW'(CMD_PULSES)) begin
                    n_skip_pos = idx_ext;
                end
            end
            if (n_skip_pos != '0 && idx_ext == n_skip_pos) begin
                n_past_stop = 1'b1;
            end else if (r_bit_count < BCW'(MAX_BYTES * 8)) begin
                n_bit_count = bc_inc;
                n_shift     = shift_in;
                if (bc_inc[2:0] == 3'd0) begin
                    emit                   = 1'b1;
                    n_out_data.kind        = KIND_DATA;
                    n_out_data.byte_value  = shift_in;
                    n_out_data.byte_index  = 6'(byte_no);
                    n_out_data.in_response = r_past_stop;
                    n_shift                = '0;
                    if (byte_no == '0) begin
                        n_cmd = shift_in;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_index <= '0;
            r_bit_count   <= '0;
            r_skip_pos    <= '0;
            r_last_bad    <= '0;
            r_shift       <= '0;
            r_cmd         <= '0;
            r_past_stop   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_pulse_index <= n_pulse_index;
                r_bit_count   <= n_bit_count;
                r_skip_pos    <= n_skip_pos;
                r_last_bad    <= n_last_bad;
                r_shift       <= n_shift;
                r_cmd         <= n_cmd;
                r_past_stop   <= n_past_stop;
            end
            if (o_q_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && emit) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

>>> design/joybus_pulse_frame_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joybus_pulse_frame_decoder
// One-wire pulse frame decoder: pulses in, data bytes and frame summaries out.
// ---------------------------------------------------------------------------
// Input channel (i_in_*): one transaction per measured pulse, low and high
// tick counts; a high count of zero ends the frame. Output channel
// (o_out_*): a data byte every eight kept bits, and one summary (byte count,
// last out-of-window pulse index) at end of frame. Configuration channel
// (i_cfg_*): period window and one threshold, written while the block is
// idle; o_cfg_ready is always high and indexes past the list are ignored.
// Throughput is one pulse per cycle while the receiver keeps up. A result
// reaches the output through the queue and the output register: the front
// classifies combinationally, the queue captures the class when the pulse
// is accepted, and the frame state logic loads the output register on pop.
// When the receiver stalls, the output register holds, the queue
// fills, and o_in_ready drops once both queue entries are taken.
// Synchronous reset clears the frame state, the queue and the output valid
// flag, and loads the configuration reset values.
// ---------------------------------------------------------------------------
module joybus_pulse_frame_decoder import jpfd_pkg::*; #(
    parameter int MAX_BYTES  = DEF_MAX_BYTES,
    parameter int MAX_PULSES = DEF_MAX_PULSES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pulse      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data
);

    t_pulse_cls cls;
    t_pulse_cls q_data;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic       push;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign push        = i_in_valid && !q_full;

    jpfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pulse     (i_in_data),
        .o_cls       (cls)
    );

    jpfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    jpfd_back #(
        .MAX_BYTES  (MAX_BYTES),
        .MAX_PULSES (MAX_PULSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
